// ===== sv/fpn_pkg.sv =====
// Shared types, constants, permutation table and helper functions for the fractal noise block.
`timescale 1ns / 1ps
`default_nettype none
package fpn_pkg;

    localparam int MAX_OCTAVES_DEF = 4;
    localparam int NUM_OFFSET_REGS = 4;
    localparam int CELL_STAGES     = 9;
    localparam int T_W             = 40;
    localparam int S_W             = 24;
    localparam int FREQ_W          = 24;
    localparam int AMPL_W          = 17;
    localparam int DOT_W           = 19;
    localparam int CONTRIB_W       = 20;
    localparam int OUT_W           = 25;
    localparam int OFFSET_W        = 48;
    localparam int CFG_W           = 48;

    localparam logic [AMPL_W-1:0] Q16_ONE  = 17'h10000;
    localparam logic [FREQ_W-1:0] FREQ_ONE = 24'h010000;
    localparam logic [FREQ_W-1:0] FREQ_MAX = 24'hFFFFFF;
    localparam logic [AMPL_W-1:0] AMPL_MAX = 17'h1FFFF;

    localparam logic [2:0]        OCTAVE_COUNT_RST = 3'd4;
    localparam logic [AMPL_W-1:0] PERSISTENCE_RST  = 17'd32768;
    localparam logic [FREQ_W-1:0] LACUNARITY_RST   = 24'd131072;
    localparam logic [FREQ_W-1:0] INV_SCALE_RST    = 24'd6554;

    typedef enum logic [2:0] {
        REG_OCTAVE_COUNT = 3'd0,
        REG_PERSISTENCE  = 3'd1,
        REG_LACUNARITY   = 3'd2,
        REG_INV_SCALE    = 3'd3,
        REG_OFFSET0      = 3'd4,
        REG_OFFSET1      = 3'd5,
        REG_OFFSET2      = 3'd6,
        REG_OFFSET3      = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        GRAD_PP = 2'd0,
        GRAD_NP = 2'd1,
        GRAD_PN = 2'd2,
        GRAD_NN = 2'd3
    } grad_sel_t;

    // Sample context handed from one octave cell to the next.
    typedef struct packed {
        logic           valid;
        logic [T_W-1:0] tx;
        logic [T_W-1:0] ty;
    } fpn_ctx_t;

    localparam logic [7:0] PERM_TABLE [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
        return PERM_TABLE[idx];
    endfunction

    function automatic logic signed [DOT_W-1:0] grad_dot(
        input logic [1:0]              hash,
        input logic signed [DOT_W-1:0] dx,
        input logic signed [DOT_W-1:0] dy
    );
        logic signed [DOT_W-1:0] res;
        case (grad_sel_t'(hash))
            GRAD_PP: res = dx + dy;
            GRAD_NP: res = dy - dx;
            GRAD_PN: res = dx - dy;
            default: res = -dx - dy;
        endcase
        return res;
    endfunction

    // a + round((b - a) * w / 2^16); the true result stays between a and b,
    // so the low bits of the rounded step are enough.
    function automatic logic signed [DOT_W-1:0] lerp_q16(
        input logic signed [DOT_W-1:0] a,
        input logic signed [DOT_W-1:0] b,
        input logic [AMPL_W-1:0]       w
    );
        logic signed [DOT_W:0]    diff;
        logic signed [DOT_W+18:0] prod;
        diff = (DOT_W+1)'(b) - (DOT_W+1)'(a);
        prod = (DOT_W+19)'(diff) * (DOT_W+19)'(signed'({1'b0, w}))
               + (DOT_W+19)'(32768);
        return a + signed'(prod[DOT_W+15:16]);
    endfunction

endpackage
`default_nettype wire

// ===== sv/fractal_perlin_noise_2d.sv =====
// A sample passes the front stage register, the octave cells and the output buffer in turn.
// Throughput: one sample per cycle while the output buffer can take a result; every octave
// cell is a fully pipelined nine-stage unit. Two result registers at the output let a new
// sample enter while a result waits. Reset (rst_n, asynchronous, active low) empties the
// pipeline and output buffer and loads the default configuration. Frequency and amplitude
// per octave follow a configuration write ahead of any sample reaching them.
`timescale 1ns / 1ps
`default_nettype none
module fractal_perlin_noise_2d import fpn_pkg::*; #(
    parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               sample_valid,
    output logic                    sample_ready,
    input  wire logic signed [31:0] x_coord,
    input  wire logic signed [31:0] y_coord,
    output logic                    noise_valid,
    input  wire logic               noise_ready,
    output logic signed [OUT_W-1:0] noise_value
);

    // Accumulator width: one octave contribution plus growth over all octaves.
    localparam int SUM_W = CONTRIB_W + $clog2(MAX_OCTAVES + 1);
    localparam logic [3:0] MAX_OCT_L = 4'(MAX_OCTAVES);

    // Configuration registers.
    logic [2:0]          octave_count_reg;
    logic [AMPL_W-1:0]   persistence_reg;
    logic [FREQ_W-1:0]   lacunarity_reg;
    logic [FREQ_W-1:0]   inv_scale_reg;
    logic [OFFSET_W-1:0] offset_reg [NUM_OFFSET_REGS];

    // Front stage: both coordinates times the inverse scale.
    logic                front_vld_reg;
    logic signed [56:0]  px_prod;
    logic signed [56:0]  py_prod;
    logic [T_W-1:0]      tx_reg;
    logic [T_W-1:0]      ty_reg;

    // Links along the chain of octave cells.
    fpn_ctx_t                ctx_link  [MAX_OCTAVES+1];
    logic signed [SUM_W-1:0] sum_link  [MAX_OCTAVES+1];
    logic [FREQ_W-1:0]       freq_link [MAX_OCTAVES+1];
    logic [AMPL_W-1:0]       ampl_link [MAX_OCTAVES+1];
    logic [3:0]              oct_lim;

    // Output buffer.
    logic [OUT_W-1:0] buf_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic             en;
    logic             push;
    logic             pop;
    logic signed [31:0]     sum_wide;
    logic signed [OUT_W-1:0] sat_value;

    // The whole pipeline moves whenever the output buffer can take a result.
    assign en           = (cnt_reg != 2'd2) || noise_ready;
    assign sample_ready = en;
    assign push         = en && ctx_link[MAX_OCTAVES].valid;
    assign pop          = noise_valid && noise_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= OCTAVE_COUNT_RST;
            persistence_reg  <= PERSISTENCE_RST;
            lacunarity_reg   <= LACUNARITY_RST;
            inv_scale_reg    <= INV_SCALE_RST;
            for (int i = 0; i < NUM_OFFSET_REGS; i++)
            begin
                offset_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index)) inside
                REG_OCTAVE_COUNT: octave_count_reg <= cfg_data[2:0];
                REG_PERSISTENCE:  persistence_reg  <= cfg_data[AMPL_W-1:0];
                REG_LACUNARITY:   lacunarity_reg   <= cfg_data[FREQ_W-1:0];
                REG_INV_SCALE:    inv_scale_reg    <= cfg_data[FREQ_W-1:0];
                REG_OFFSET0, REG_OFFSET1, REG_OFFSET2, REG_OFFSET3:
                    offset_reg[cfg_index[1:0]] <= cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Front stage. Only the low 56 product bits are kept, and the sample
    // coordinate takes bits 55:16 of them.
    assign px_prod = 57'(x_coord) * 57'(signed'({1'b0, inv_scale_reg}));
    assign py_prod = 57'(y_coord) * 57'(signed'({1'b0, inv_scale_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            front_vld_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_reg <= px_prod[55:16];
            ty_reg <= py_prod[55:16];
        end
    end

    // Octave count limited to the number of cells in the chain.
    assign oct_lim = ({1'b0, octave_count_reg} > MAX_OCT_L) ? MAX_OCT_L
                                                           : {1'b0, octave_count_reg};

    assign ctx_link[0].valid = front_vld_reg;
    assign ctx_link[0].tx    = tx_reg;
    assign ctx_link[0].ty    = ty_reg;
    assign sum_link[0]       = '0;
    assign freq_link[0]      = FREQ_ONE;
    assign ampl_link[0]      = Q16_ONE;

    // One cell per octave. Each cell adds its octave when it lies below the
    // configured octave count, and hands the sample to its neighbor.
    for (genvar k = 0; k < MAX_OCTAVES; k++)
    begin : g_oct
        logic [S_W-1:0] off_x;
        logic [S_W-1:0] off_y;
        logic           active;

        if (k < NUM_OFFSET_REGS)
        begin : g_off
            assign off_x = offset_reg[k][47:24];
            assign off_y = offset_reg[k][23:0];
        end
        else
        begin : g_no_off
            assign off_x = '0;
            assign off_y = '0;
        end

        assign active = (4'(k) < oct_lim);

        fpn_cell #(
            .SUM_W (SUM_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (en),
            .active      (active),
            .freq_in     (freq_link[k]),
            .ampl_in     (ampl_link[k]),
            .lacunarity  (lacunarity_reg),
            .persistence (persistence_reg),
            .offset_x    (off_x),
            .offset_y    (off_y),
            .ctx_in      (ctx_link[k]),
            .sum_in      (sum_link[k]),
            .ctx_out     (ctx_link[k+1]),
            .sum_out     (sum_link[k+1]),
            .freq_out    (freq_link[k+1]),
            .ampl_out    (ampl_link[k+1])
        );
    end

    // Saturate the octave sum to signed Q8.16.
    assign sum_wide = 32'(sum_link[MAX_OCTAVES]);

    always_comb
    begin
        if (sum_wide > 32'sd16777215)
        begin
            sat_value = OUT_W'(32'sd16777215);
        end
        else if (sum_wide < -32'sd16777216)
        begin
            sat_value = OUT_W'(-32'sd16777216);
        end
        else
        begin
            sat_value = sum_wide[OUT_W-1:0];
        end
    end

    // Two-entry output buffer: a result can wait here while the pipeline
    // keeps taking samples.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= sat_value;
        end
    end

    assign noise_valid = (cnt_reg != 2'd0);
    assign noise_value = signed'(buf_reg[rd_ptr_reg]);

endmodule
`default_nettype wire

// ===== sv/fpn_axis.sv =====
// One axis of an octave: scaled sample coordinate, lattice index, fraction and quintic fade.
`timescale 1ns / 1ps
`default_nettype none
module fpn_axis import fpn_pkg::*; (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [T_W-1:0]    t,
    input  wire logic [FREQ_W-1:0] freq,
    input  wire logic [S_W-1:0]    offset,
    output logic [7:0]             cell_idx,
    output logic [15:0]            frac,
    output logic [AMPL_W-1:0]      fade
);

    logic [47:0]       lo_reg;
    logic [15:0]       hi_reg;
    logic [S_W-1:0]    s_reg;
    logic [15:0]       f3_reg;
    logic [15:0]       f4_reg;
    logic [15:0]       t2_reg;
    logic [15:0]       t3_reg;
    logic [20:0]       p_reg;
    logic [AMPL_W-1:0] fade_reg;

    logic [47:0]       lo_next;
    logic [39:0]       hi_prod;
    logic [S_W-1:0]    s_next;
    logic [31:0]       sq;
    logic [31:0]       cube;
    logic [20:0]       p_next;
    logic [36:0]       fprod;
    logic [AMPL_W-1:0] fade_next;

    // Only the low 40 bits of t * freq matter, so the upper part of t
    // contributes only its low 16 product bits.
    assign lo_next = 48'(t[23:0]) * 48'(freq);
    assign hi_prod = 40'(t[39:24]) * 40'(freq);
    assign s_next  = lo_reg[39:16] + {hi_reg, 8'h00} + offset;

    assign sq     = 32'(s_reg[15:0]) * 32'(s_reg[15:0]);
    assign cube   = 32'(t2_reg) * 32'(f3_reg);
    assign p_next = 21'd655360 + 21'(t2_reg) * 21'd6 - 21'(f3_reg) * 21'd15;
    assign fprod  = 37'(t3_reg) * 37'(p_reg) + 37'd32768;
    assign fade_next = (fprod[36:16] > 21'(Q16_ONE)) ? Q16_ONE : fprod[32:16];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_prod[15:0];
            s_reg    <= s_next;
            f3_reg   <= s_reg[15:0];
            t2_reg   <= sq[31:16];
            f4_reg   <= f3_reg;
            t3_reg   <= cube[31:16];
            p_reg    <= p_next;
            fade_reg <= fade_next;
        end
    end

    assign cell_idx = s_reg[23:16];
    assign frac     = f4_reg;
    assign fade     = fade_reg;

endmodule
`default_nettype wire

// ===== sv/fpn_cell.sv =====
// One octave cell: samples, hashes, blends and accumulates one octave, then passes the sample on.
`timescale 1ns / 1ps
`default_nettype none
module fpn_cell import fpn_pkg::*; #(
    parameter int SUM_W = CONTRIB_W + 2
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     active,
    input  wire logic [FREQ_W-1:0]        freq_in,
    input  wire logic [AMPL_W-1:0]        ampl_in,
    input  wire logic [FREQ_W-1:0]        lacunarity,
    input  wire logic [AMPL_W-1:0]        persistence,
    input  wire logic [S_W-1:0]           offset_x,
    input  wire logic [S_W-1:0]           offset_y,
    input  wire fpn_ctx_t                 ctx_in,
    input  wire logic signed [SUM_W-1:0]  sum_in,
    output fpn_ctx_t                      ctx_out,
    output logic signed [SUM_W-1:0]       sum_out,
    output logic [FREQ_W-1:0]             freq_out,
    output logic [AMPL_W-1:0]             ampl_out
);

    logic [CELL_STAGES-1:0]  vld_pipe_reg;
    logic [T_W-1:0]          tx_pipe_reg [CELL_STAGES];
    logic [T_W-1:0]          ty_pipe_reg [CELL_STAGES];
    logic signed [SUM_W-1:0] sum_pipe_reg [CELL_STAGES-1];
    logic signed [SUM_W-1:0] sum_reg;

    logic [FREQ_W-1:0] freq_reg;
    logic [AMPL_W-1:0] ampl_reg;
    logic [48:0]       freq_prod;
    logic [34:0]       ampl_prod;
    logic [FREQ_W-1:0] freq_next;
    logic [AMPL_W-1:0] ampl_next;

    logic [7:0]        cx;
    logic [7:0]        cy;
    logic [15:0]       fx;
    logic [15:0]       fy;
    logic [AMPL_W-1:0] fade_u;
    logic [AMPL_W-1:0] fade_v;

    logic [7:0] ha_reg;
    logic [7:0] hb_reg;
    logic [7:0] cy_reg;
    logic [7:0] h00_reg;
    logic [7:0] h01_reg;
    logic [7:0] h10_reg;
    logic [7:0] h11_reg;

    logic signed [DOT_W-1:0] dx0;
    logic signed [DOT_W-1:0] dx1;
    logic signed [DOT_W-1:0] dy0;
    logic signed [DOT_W-1:0] dy1;
    logic signed [DOT_W-1:0] d00_reg;
    logic signed [DOT_W-1:0] d01_reg;
    logic signed [DOT_W-1:0] d10_reg;
    logic signed [DOT_W-1:0] d11_reg;
    logic signed [DOT_W-1:0] l0_reg;
    logic signed [DOT_W-1:0] l1_reg;
    logic [AMPL_W-1:0]       v6_reg;
    logic signed [DOT_W-1:0] noise_reg;

    logic signed [36:0]          cprod;
    logic signed [CONTRIB_W-1:0] contrib_reg;
    logic signed [SUM_W-1:0]     sum_next;

    // Frequency and amplitude of the next octave, registered and settled in the cycle
    // after those of this octave.
    assign freq_prod = 49'(freq_in) * 49'(lacunarity) + 49'd32768;
    assign ampl_prod = 35'(ampl_in) * 35'(persistence) + 35'd32768;
    assign freq_next = (freq_prod[48:16] > 33'(FREQ_MAX)) ? FREQ_MAX : freq_prod[39:16];
    assign ampl_next = (ampl_prod[34:16] > 19'(AMPL_MAX)) ? AMPL_MAX : ampl_prod[32:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg     <= '0;
            ampl_reg     <= '0;
            vld_pipe_reg <= '0;
        end
        else
        begin
            freq_reg <= freq_next;
            ampl_reg <= ampl_next;
            if (en)
            begin
                vld_pipe_reg <= {vld_pipe_reg[CELL_STAGES-2:0], ctx_in.valid};
            end
        end
    end

    fpn_axis u_axis_x (
        .clk      (clk),
        .en       (en),
        .t        (ctx_in.tx),
        .freq     (freq_in),
        .offset   (offset_x),
        .cell_idx (cx),
        .frac     (fx),
        .fade     (fade_u)
    );

    fpn_axis u_axis_y (
        .clk      (clk),
        .en       (en),
        .t        (ctx_in.ty),
        .freq     (freq_in),
        .offset   (offset_y),
        .cell_idx (cy),
        .frac     (fy),
        .fade     (fade_v)
    );

    assign dx0 = signed'(DOT_W'(fx));
    assign dy0 = signed'(DOT_W'(fy));
    assign dx1 = dx0 - DOT_W'(32'sd65536);
    assign dy1 = dy0 - DOT_W'(32'sd65536);

    assign cprod    = 37'(noise_reg) * 37'(signed'({1'b0, ampl_in})) + 37'sd32768;
    assign sum_next = sum_pipe_reg[CELL_STAGES-2]
                      + (active ? SUM_W'(contrib_reg) : SUM_W'(0));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx_pipe_reg[0]  <= ctx_in.tx;
            ty_pipe_reg[0]  <= ctx_in.ty;
            sum_pipe_reg[0] <= sum_in;
            for (int i = 1; i < CELL_STAGES; i++)
            begin
                tx_pipe_reg[i] <= tx_pipe_reg[i-1];
                ty_pipe_reg[i] <= ty_pipe_reg[i-1];
            end
            for (int i = 1; i < CELL_STAGES - 1; i++)
            begin
                sum_pipe_reg[i] <= sum_pipe_reg[i-1];
            end

            ha_reg  <= perm_lookup(cx);
            hb_reg  <= perm_lookup(cx + 8'd1);
            cy_reg  <= cy;
            h00_reg <= perm_lookup(ha_reg + cy_reg);
            h01_reg <= perm_lookup(ha_reg + cy_reg + 8'd1);
            h10_reg <= perm_lookup(hb_reg + cy_reg);
            h11_reg <= perm_lookup(hb_reg + cy_reg + 8'd1);

            d00_reg <= grad_dot(h00_reg[1:0], dx0, dy0);
            d01_reg <= grad_dot(h01_reg[1:0], dx0, dy1);
            d10_reg <= grad_dot(h10_reg[1:0], dx1, dy0);
            d11_reg <= grad_dot(h11_reg[1:0], dx1, dy1);

            l0_reg    <= lerp_q16(d00_reg, d10_reg, fade_u);
            l1_reg    <= lerp_q16(d01_reg, d11_reg, fade_u);
            v6_reg    <= fade_v;
            noise_reg <= lerp_q16(l0_reg, l1_reg, v6_reg);

            contrib_reg <= signed'(cprod[CONTRIB_W+15:16]);
            sum_reg     <= sum_next;
        end
    end

    assign ctx_out.valid = vld_pipe_reg[CELL_STAGES-1];
    assign ctx_out.tx    = tx_pipe_reg[CELL_STAGES-1];
    assign ctx_out.ty    = ty_pipe_reg[CELL_STAGES-1];
    assign sum_out       = sum_reg;
    assign freq_out      = freq_reg;
    assign ampl_out      = ampl_reg;

endmodule
`default_nettype wire

// ===== sv/fpn_checker.sv =====
// Port-level checks for the fractal noise block and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none
module fpn_checker import fpn_pkg::*; (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    sample_valid,
    input wire logic                    sample_ready,
    input wire logic                    noise_valid,
    input wire logic                    noise_ready,
    input wire logic signed [OUT_W-1:0] noise_value
);

    // Nothing is offered in the first cycle out of reset.
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !noise_valid)
        else $error("result offered straight out of reset");

    // The input side only stalls when a result is waiting and not taken.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> (noise_valid && !noise_ready))
        else $error("input stalled without back pressure");

    // A result that is offered and not taken stays offered and unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (noise_valid && !noise_ready) |=> (noise_valid && $stable(noise_value)))
        else $error("stalled result changed or vanished");

    // A stalled input with a stalled output keeps the buffer full, so the input
    // side can only resume together with the output side.
    a_both_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_ready && !noise_ready) |=>
            (noise_valid && (sample_ready == noise_ready)))
        else $error("input side resumed while output buffer full");

endmodule

bind fractal_perlin_noise_2d fpn_checker u_fpn_checker (.*);
`default_nettype wire

// ===== verif/tb_fractal_perlin_noise_2d.sv =====
// Self-checking testbench for the fractal 2D gradient noise block.
`timescale 1ns / 1ps
`default_nettype none

// Holds the noise configuration, predicts each sample and matches the results in order.
class noise_scoreboard;
    bit [2:0]  octave_count;
    bit [16:0] persistence;
    bit [23:0] lacunarity;
    bit [23:0] inv_scale;
    bit [47:0] offsets [4];
    bit signed [24:0] pending_noise [$];
    int errors;
    int checked;

    function new();
        errors = 0;
        checked = 0;
        set_defaults();
    endfunction

    function void set_defaults();
        octave_count = 3'd4;
        persistence  = 17'd32768;
        lacunarity   = 24'd131072;
        inv_scale    = 24'd6554;
        foreach (offsets[i]) offsets[i] = '0;
    endfunction

    function void write_reg(fpn_pkg::cfg_reg_t idx, bit [47:0] data);
        case (idx)
            fpn_pkg::REG_OCTAVE_COUNT: octave_count = data[2:0];
            fpn_pkg::REG_PERSISTENCE:  persistence  = data[16:0];
            fpn_pkg::REG_LACUNARITY:   lacunarity   = data[23:0];
            fpn_pkg::REG_INV_SCALE:    inv_scale    = data[23:0];
            default:                   offsets[idx - fpn_pkg::REG_OFFSET0] = data;
        endcase
    endfunction

    // Arithmetic floor((v + 2^15) / 2^16).
    function longint round16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function longint fade(longint f);
        longint t2, t3, p, r;
        t2 = (f * f) >> 16;
        t3 = (t2 * f) >> 16;
        p  = 6 * t2 + 10 * 65536 - 15 * f;
        r  = (t3 * p + 32768) >> 16;
        return (r > 65536) ? 65536 : r;
    endfunction

    function longint gradient(bit [7:0] h, longint dx, longint dy);
        case (fpn_pkg::grad_sel_t'(h[1:0]))
            fpn_pkg::GRAD_PP: return dx + dy;
            fpn_pkg::GRAD_NP: return dy - dx;
            fpn_pkg::GRAD_PN: return dx - dy;
            default:          return -dx - dy;
        endcase
    endfunction

    function bit [7:0] lattice_hash(bit [7:0] cx, bit [7:0] cy);
        bit [7:0] row;
        row = fpn_pkg::PERM_TABLE[cx];
        return fpn_pkg::PERM_TABLE[8'(row + cy)];
    endfunction

    function bit [23:0] scaled_coord(longint c, longint freq, bit [23:0] off);
        bit [63:0] prod;
        bit [63:0] t;
        prod = c * longint'(inv_scale);
        t = {8'h0, prod[55:0]} >> 16;
        return 24'(((t * freq) >> 16) + off);
    endfunction

    function longint cell_noise(bit [23:0] sx, bit [23:0] sy);
        bit [7:0] cx, cy;
        longint fx, fy, u, v, d00, d01, d10, d11, a, b;
        cx = sx[23:16];
        cy = sy[23:16];
        fx = longint'(sx[15:0]);
        fy = longint'(sy[15:0]);
        u = fade(fx);
        v = fade(fy);
        d00 = gradient(lattice_hash(cx, cy), fx, fy);
        d01 = gradient(lattice_hash(cx, 8'(cy + 1)), fx, fy - 65536);
        d10 = gradient(lattice_hash(8'(cx + 1), cy), fx - 65536, fy);
        d11 = gradient(lattice_hash(8'(cx + 1), 8'(cy + 1)), fx - 65536, fy - 65536);
        a = d00 + round16((d10 - d00) * u);
        b = d01 + round16((d11 - d01) * u);
        return a + round16((b - a) * v);
    endfunction

    function void note_sample(bit signed [31:0] x, bit signed [31:0] y);
        longint ampl, freq, total;
        int n;
        bit [23:0] sx, sy;
        ampl = 65536;
        freq = 65536;
        total = 0;
        n = (octave_count > 4) ? 4 : octave_count;
        for (int i = 0; i < n; i++) begin
            sx = scaled_coord(longint'(x), freq, offsets[i][47:24]);
            sy = scaled_coord(longint'(y), freq, offsets[i][23:0]);
            total += round16(cell_noise(sx, sy) * ampl);
            ampl = (ampl * persistence + 32768) >> 16;
            if (ampl > 131071) ampl = 131071;
            freq = (freq * lacunarity + 32768) >> 16;
            if (freq > 16777215) freq = 16777215;
        end
        if (total > 16777215) total = 16777215;
        if (total < -16777216) total = -16777216;
        pending_noise.insert(pending_noise.size(), 25'(total));
    endfunction

    function void check_noise(bit signed [24:0] got);
        bit signed [24:0] want;
        checked++;
        if (pending_noise.size() == 0) begin
            $error("noise_value: unexpected result %0d", got);
            errors++;
            return;
        end
        want = pending_noise.pop_front();
        if (got !== want) begin
            $error("noise_value: expected %0d, got %0d", want, got);
            errors++;
        end
    endfunction
endclass

module tb_fractal_perlin_noise_2d;
    import fpn_pkg::*;

    // Cycles from an input transfer to the matching result being offered.
    localparam int PIPE_LATENCY = 9 * MAX_OCTAVES_DEF + 1;
    localparam longint CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               sample_valid;
    logic               sample_ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic               noise_valid;
    logic               noise_ready;
    logic signed [24:0] noise_value;

    noise_scoreboard board;
    longint cycle_count;
    int     samples_sent;
    bit     sink_hold;   // set by the stimulus to force a long output stall
    bit     sink_gaps;   // enables random stalls on the output side

    fractal_perlin_noise_2d i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .noise_valid  (noise_valid),
        .noise_ready  (noise_ready),
        .noise_value  (noise_value)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Runaway guard: a stuck handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles.", cycle_count);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Results are sampled on the clock edge, ahead of any nonblocking update.
    always @(posedge clk) begin
        if (rst_n && noise_valid && noise_ready)
            board.check_noise(noise_value);
    end

    // The output side stalls at random once gaps are enabled; a hold request keeps it stalled
    // long enough for the pipeline to fill and push back on the input.
    initial begin
        int stall;
        noise_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (sink_hold) begin
                noise_ready <= 1'b0;
                for (int i = 0; i < 300; i++) @(posedge clk);
                sink_hold = 1'b0;
                noise_ready <= 1'b1;
            end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
                noise_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                noise_ready <= 1'b1;
            end else begin
                noise_ready <= 1'b1;
            end
        end
    end

    // Offer one sample, after an optional random idle gap, and hold it until the transfer happens.
    task automatic send_sample(input logic signed [31:0] x, input logic signed [31:0] y,
                               input bit gaps);
        int idle;
        if (gaps && $urandom_range(0, 3) == 0) begin
            idle = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                               : $urandom_range(1, 3);
            sample_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        sample_valid <= 1'b1;
        x_coord      <= x;
        y_coord      <= y;
        do @(posedge clk); while (!sample_ready);
        board.note_sample(x, y);
        samples_sent++;
    endtask

    task automatic end_burst();
        sample_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Configuration is only touched with the pipeline empty.
    task automatic drain();
        while (board.pending_noise.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // The write strobe drops for a cycle between writes.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.write_reg(idx, data);
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] any_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed(32'($urandom_range(0, 20'hFFFFF)));
            2:       return -$signed(32'($urandom_range(0, 20'hFFFFF)));
            default: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        endcase
    endfunction

    // One phase: a fresh random setting followed by a burst of random samples.
    task automatic random_phase(input int count, input bit ext);
        logic [23:0] v;
        logic [16:0] pers;
        write_reg(REG_OCTAVE_COUNT,
                  CFG_W'(ext ? $urandom_range(0, 7) : $urandom_range(1, 4)));
        pers = ($urandom_range(0, 3) == 0) ? 17'h10000 : 17'($urandom);
        write_reg(REG_PERSISTENCE, CFG_W'(pers));
        v = ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 24'h40000));
        write_reg(REG_LACUNARITY, CFG_W'(v));
        v = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 24'h20000));
        write_reg(REG_INV_SCALE, CFG_W'(v));
        for (int i = 0; i < 4; i++)
            write_reg(cfg_reg_t'(REG_OFFSET0 + i), CFG_W'({$urandom, $urandom}));
        for (int i = 0; i < count; i++) begin
            if (i == count / 2 && $urandom_range(0, 1) == 0)
                ; // does nothing; only the first third of the burst is sent without input gaps
            send_sample(any_coord(), $urandom_range(0, 5) == 0 ? 32'sd0 : any_coord(),
                        i >= count / 3);
        end
        end_burst();
        drain();
    endtask

    initial begin
        board        = new();
        samples_sent = 0;
        sink_hold    = 1'b0;
        sink_gaps    = 1'b0;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_OCTAVE_COUNT;
        cfg_data     = '0;
        sample_valid = 1'b0;
        x_coord      = '0;
        y_coord      = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings with coordinate extremes, 1D noise and lattice wrap.
        send_sample(32'sd0, 32'sd0, 1'b0);
        send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
        send_sample(32'sh80000000, 32'sh80000000, 1'b0);
        send_sample(32'sh7FFFFFFF, 32'sh80000000, 1'b0);
        send_sample(32'sh0012_3456, 32'sd0, 1'b0);
        send_sample(-32'sh0001_0000, 32'sh0000_8000, 1'b0);
        send_sample(32'shFFFFFFFF, 32'sh5555AAAA, 1'b0);
        end_burst();
        drain();

        // Zero octaves gives a zero sum; counts above the maximum are clamped.
        write_reg(REG_OCTAVE_COUNT, CFG_W'(3'd0));
        send_sample(32'sh1234_5678, 32'sh0765_4321, 1'b0);
        end_burst();
        drain();
        write_reg(REG_OCTAVE_COUNT, CFG_W'(3'd7));
        write_reg(REG_PERSISTENCE, CFG_W'(17'h1FFFF));     // amplitude saturates
        write_reg(REG_LACUNARITY, CFG_W'(24'hFFFFFF));     // frequency saturates
        write_reg(REG_INV_SCALE, CFG_W'(24'hFFFFFF));
        write_reg(REG_OFFSET0, 48'hFFFFFF_FFFFFF);
        write_reg(REG_OFFSET1, 48'hFF8000_FF8000);
        write_reg(REG_OFFSET2, 48'h000000_FFFFFF);
        write_reg(REG_OFFSET3, 48'hAAAAAA_555555);
        send_sample(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
        send_sample(32'sh80000000, 32'sh0000_FFFF, 1'b0);
        send_sample(32'sh0000_FFFF, 32'sd0, 1'b0);
        send_sample(32'sh00FF_0000, 32'sh00FF_0000, 1'b0);
        end_burst();
        drain();

        // Zero inverse scale with unit persistence and lacunarity, then zero persistence and lacunarity.
        write_reg(REG_OCTAVE_COUNT, CFG_W'(3'd4));
        write_reg(REG_PERSISTENCE, CFG_W'(17'h10000));
        write_reg(REG_LACUNARITY, CFG_W'(24'h010000));
        write_reg(REG_INV_SCALE, CFG_W'(24'd0));
        send_sample(32'sh1111_1111, 32'sh2222_2222, 1'b0);
        end_burst();
        drain();
        write_reg(REG_INV_SCALE, CFG_W'(24'h010000));
        write_reg(REG_PERSISTENCE, CFG_W'(17'd0));
        write_reg(REG_LACUNARITY, CFG_W'(24'd0));
        for (int i = 0; i < 8; i++)
            send_sample(any_coord(), any_coord(), 1'b0);
        end_burst();
        drain();

        // Back-pressure: the output stalls long while samples keep coming.
        sink_gaps = 1'b1;
        sink_hold = 1'b1;
        for (int i = 0; i < 80; i++)
            send_sample(any_coord(), any_coord(), 1'b0);
        end_burst();
        drain();

        // Random phases, with an extreme-count setting now and then.
        for (int p = 0; p < 12; p++)
            random_phase(50, p % 3 == 0);

        // Put the reset values back and run once more.
        write_reg(REG_OCTAVE_COUNT, CFG_W'(3'd4));
        write_reg(REG_PERSISTENCE, CFG_W'(17'd32768));
        write_reg(REG_LACUNARITY, CFG_W'(24'd131072));
        write_reg(REG_INV_SCALE, CFG_W'(24'd6554));
        for (int i = 0; i < 4; i++)
            write_reg(cfg_reg_t'(REG_OFFSET0 + i), '0);
        for (int i = 0; i < 40; i++)
            send_sample(any_coord(), any_coord(), 1'b1);
        end_burst();
        drain();

        $display("Sent %0d samples over directed and random register settings; %0d checked.",
                 samples_sent, board.checked);
        $display("Covered octave counts 0 to 7, saturated amplitude and frequency, output stalls.");
        if (board.errors == 0 && board.pending_noise.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== fractal_perlin_noise_2d.f =====
sv/fpn_pkg.sv
sv/fpn_axis.sv
sv/fpn_cell.sv
sv/fractal_perlin_noise_2d.sv
sv/fpn_checker.sv
verif/tb_fractal_perlin_noise_2d.sv
